// ===== src/ppa_pkg.sv =====
// shared types, field widths and codes of the physical page allocator
package ppa_pkg;

   localparam int CMD_W      = 4;
   localparam int PAGE_W     = 12;
   localparam int STATUS_W   = 3;
   localparam int ADDR_W     = 64;
   localparam int REFOUT_W   = 16;
   localparam int COUNT_W    = 13;
   localparam int BASE_W     = 52;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam int PAGES_DEF      = 4096;
   localparam int PAGE_SHIFT_DEF = 12;
   localparam int REF_BITS_DEF   = 16;

   localparam logic [COUNT_W-1:0] PAGE_COUNT_RST = 13'd4096;

   localparam logic [CMD_W-1:0] CMD_INIT      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC     = 4'd1;
   localparam logic [CMD_W-1:0] CMD_FREE      = 4'd2;
   localparam logic [CMD_W-1:0] CMD_ADD_REF   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_DROP_REF  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_SET_DIRTY = 4'd5;
   localparam logic [CMD_W-1:0] CMD_CLR_DIRTY = 4'd6;
   localparam logic [CMD_W-1:0] CMD_TST_DIRTY = 4'd7;
   localparam logic [CMD_W-1:0] CMD_TRYLOCK   = 4'd8;
   localparam logic [CMD_W-1:0] CMD_UNLOCK    = 4'd9;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LOCK_BUSY = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_MEM_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FREE = 2'd2;

   typedef logic [1:0] alu_op_type;

   localparam alu_op_type ALU_PASS = 2'd0;
   localparam alu_op_type ALU_INC  = 2'd1;
   localparam alu_op_type ALU_DEC  = 2'd2;

endpackage

// ===== src/ppa_ram.sv =====
// generic single write port ram with registered read
module ppa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/ppa_alu.sv =====
// shared step and compare unit of the allocator sequencer
module ppa_alu #(
   parameter int WIDTH = 16
) (
   input  ppa_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]    a,
   input  logic [WIDTH-1:0]    b,
   output logic [WIDTH-1:0]    sum,
   output logic                lt
);

   import ppa_pkg::*;

   always_comb begin
      unique case (op)
         ALU_INC: sum = a + WIDTH'(1);
         ALU_DEC: sum = a - WIDTH'(1);
         default: sum = a;
      endcase
   end

   assign lt = a < b;

endmodule

// ===== src/physical_page_allocator_unit.sv =====
// page frame allocator: free stack, per-page table and command sequencer
//
// Commands enter on req_cmd / req_page_number and are taken at a clock edge
// where start is high and busy is low. Each command gives one result on the
// rsp_ ports, marked by rsp_valid for exactly one cycle; the receiver cannot
// stall, so the result must be taken in that cycle.
// Registers are written on the csr_ channel (csr_ready is always high); the
// user must write them only while the block is idle, which the block does
// not enforce: index 0 base frame, 1 page count, 2 first free page.
// Steps from the accepting edge to the rsp_valid cycle:
//   alloc and per-page commands: a check state, then a pop or modify state
//   fed by the registered read of the free stack or page table; a new
//   command can be taken in the rsp_valid cycle
//   rejected commands (invalid page or command, empty stack): answered from
//   the check state; init: clears the page table, then pushes one page per cycle
// After reset the block runs a clearing pass over the page table with busy
// high; csr writes are taken during it.
module physical_page_allocator_unit #(
   parameter int PAGES      = ppa_pkg::PAGES_DEF,
   parameter int PAGE_SHIFT = ppa_pkg::PAGE_SHIFT_DEF,
   parameter int REF_BITS   = ppa_pkg::REF_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ppa_pkg::CMD_W-1:0]      req_cmd,
   input  logic [ppa_pkg::PAGE_W-1:0]     req_page_number,
   output logic                           rsp_valid,
   output logic [ppa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ppa_pkg::PAGE_W-1:0]     rsp_page_out,
   output logic [ppa_pkg::ADDR_W-1:0]     rsp_phys_addr,
   output logic [ppa_pkg::REFOUT_W-1:0]   rsp_ref_count,
   output logic                           rsp_dirty,
   output logic [ppa_pkg::COUNT_W-1:0]    rsp_free_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ppa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ppa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import ppa_pkg::*;

   localparam int IW = $clog2(PAGES);
   localparam int DW = $clog2(PAGES + 1);
   localparam int CW = (DW > COUNT_W) ? DW : COUNT_W;
   localparam int AW = (CW > REF_BITS) ? CW : REF_BITS;
   localparam int TW = REF_BITS + 2;

   localparam logic [AW-1:0] REF_MAX_AW = AW'({REF_BITS{1'b1}});
   localparam logic [AW-1:0] PAGES_AW   = AW'(PAGES);
   localparam logic [AW-1:0] LAST_AW    = AW'(PAGES - 1);
   localparam logic [DW-1:0] PAGES_DW   = DW'(PAGES);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_ICLR   = 3'd2;
   localparam logic [2:0] S_IPUSH  = 3'd3;
   localparam logic [2:0] S_CHECK  = 3'd4;
   localparam logic [2:0] S_POP    = 3'd5;
   localparam logic [2:0] S_MODIFY = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [PAGE_W-1:0]   pg_ff, pg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]   rsp_page_ff, rsp_page_in;
   logic [ADDR_W-1:0]   rsp_phys_ff, rsp_phys_in;
   logic [REFOUT_W-1:0] rsp_ref_ff, rsp_ref_in;
   logic                rsp_dirty_ff, rsp_dirty_in;
   logic [BASE_W-1:0]   base_ff;
   logic [COUNT_W-1:0]  page_count_ff;
   logic [COUNT_W-1:0]  first_ff;

   logic                resp_full;
   logic [AW-1:0]       pc_aw, n_aw;

   alu_op_type          alu_op;
   logic [AW-1:0]       alu_a, alu_b, alu_sum;
   logic                alu_lt;

   logic                st_we;
   logic [IW-1:0]       st_waddr, st_raddr;
   logic [PAGE_W-1:0]   st_wdata, st_rdata;
   logic                tb_we;
   logic [IW-1:0]       tb_waddr, tb_raddr;
   logic [TW-1:0]       tb_wdata, tb_rdata;

   logic [REF_BITS-1:0] ref_old, ref_new;
   logic                dirty_old, dirty_new, lock_old, lock_new;

   ppa_alu #(.WIDTH(AW)) u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .sum (alu_sum),
      .lt  (alu_lt)
   );

   ppa_ram #(.WIDTH(PAGE_W), .DEPTH(PAGES)) u_stack (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   ppa_ram #(.WIDTH(TW), .DEPTH(PAGES)) u_table (
      .clock (clock),
      .we    (tb_we),
      .waddr (tb_waddr),
      .wdata (tb_wdata),
      .raddr (tb_raddr),
      .rdata (tb_rdata)
   );

   // active page count, limited to the table depth
   assign pc_aw = AW'(page_count_ff);
   assign n_aw  = (pc_aw < PAGES_AW) ? pc_aw : PAGES_AW;

   assign ref_old   = tb_rdata[REF_BITS-1:0];
   assign dirty_old = tb_rdata[REF_BITS];
   assign lock_old  = tb_rdata[REF_BITS+1];

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      depth_in      = depth_ff;
      cmd_in        = cmd_ff;
      pg_in         = pg_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_ref_in    = rsp_ref_ff;
      rsp_dirty_in  = rsp_dirty_ff;
      resp_full     = 1'b0;
      alu_op        = ALU_PASS;
      alu_a         = '0;
      alu_b         = '0;
      st_we         = 1'b0;
      st_waddr      = IW'(depth_ff);
      st_wdata      = pg_ff;
      st_raddr      = IW'(alu_sum);
      tb_we         = 1'b0;
      tb_waddr      = IW'(pg_ff);
      tb_wdata      = '0;
      tb_raddr      = IW'(pg_ff);
      ref_new       = ref_old;
      dirty_new     = dirty_old;
      lock_new      = lock_old;

      unique case (state_ff) inside
         S_CLEAR, S_ICLR: begin
            tb_we    = 1'b1;
            tb_waddr = IW'(idx_ff);
            alu_op   = ALU_INC;
            alu_a    = AW'(idx_ff);
            alu_b    = LAST_AW;
            if (alu_lt) begin
               idx_in = CW'(alu_sum);
            end else if (state_ff == S_CLEAR) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in   = CW'(first_ff);
               state_in = S_IPUSH;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in = req_cmd;
               pg_in  = req_page_number;
               if (req_cmd == CMD_INIT) begin
                  idx_in   = '0;
                  depth_in = '0;
                  state_in = S_ICLR;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_IPUSH: begin
            alu_op = ALU_INC;
            alu_a  = AW'(idx_ff);
            alu_b  = n_aw;
            if (alu_lt) begin
               st_we    = 1'b1;
               st_wdata = PAGE_W'(idx_ff);
               depth_in = depth_ff + DW'(1);
               idx_in   = CW'(alu_sum);
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_page_in   = '0;
               rsp_ref_in    = '0;
               rsp_dirty_in  = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_CHECK: begin
            if (cmd_ff == CMD_ALLOC) begin
               alu_op = ALU_DEC;
               alu_a  = AW'(depth_ff);
               if (depth_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NO_FREE;
                  rsp_page_in   = '0;
                  rsp_ref_in    = '0;
                  rsp_dirty_in  = 1'b0;
                  state_in      = S_IDLE;
               end else begin
                  depth_in = DW'(alu_sum);
                  state_in = S_POP;
               end
            end else begin
               alu_a = AW'(pg_ff);
               alu_b = n_aw;
               if (cmd_ff > CMD_UNLOCK || !alu_lt) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_INVALID;
                  rsp_page_in   = pg_ff;
                  rsp_ref_in    = '0;
                  rsp_dirty_in  = 1'b0;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_MODIFY;
               end
            end
         end
         S_POP: begin
            alu_a        = AW'(st_rdata);
            alu_b        = n_aw;
            rsp_valid_in = 1'b1;
            rsp_page_in  = st_rdata;
            state_in     = S_IDLE;
            if (!alu_lt) begin
               rsp_status_in = ST_INVALID;
               rsp_ref_in    = '0;
               rsp_dirty_in  = 1'b0;
            end else begin
               tb_we         = 1'b1;
               tb_waddr      = IW'(st_rdata);
               tb_wdata      = {2'b00, REF_BITS'(1)};
               rsp_status_in = ST_OK;
               rsp_ref_in    = REFOUT_W'(1);
               rsp_dirty_in  = 1'b0;
               resp_full     = 1'b1;
            end
         end
         S_MODIFY: begin
            rsp_status_in = ST_OK;
            case (cmd_ff)
               CMD_FREE: begin
                  if (ref_old != '0 || depth_ff == PAGES_DW) begin
                     rsp_status_in = ST_REFUSED;
                  end else begin
                     dirty_new = 1'b0;
                     lock_new  = 1'b0;
                     st_we     = 1'b1;
                     depth_in  = depth_ff + DW'(1);
                  end
               end
               CMD_ADD_REF: begin
                  alu_op = ALU_INC;
                  alu_a  = AW'(ref_old);
                  alu_b  = REF_MAX_AW;
                  if (alu_lt) begin
                     ref_new = REF_BITS'(alu_sum);
                  end
               end
               CMD_DROP_REF: begin
                  alu_op = ALU_DEC;
                  alu_a  = AW'(ref_old);
                  if (ref_old != '0) begin
                     ref_new = REF_BITS'(alu_sum);
                  end
               end
               CMD_SET_DIRTY: dirty_new = 1'b1;
               CMD_CLR_DIRTY: dirty_new = 1'b0;
               CMD_TRYLOCK: begin
                  if (lock_old) begin
                     rsp_status_in = ST_LOCK_BUSY;
                  end else begin
                     lock_new = 1'b1;
                  end
               end
               CMD_UNLOCK: lock_new = 1'b0;
               default: begin
               end
            endcase
            tb_we        = 1'b1;
            tb_wdata     = {lock_new, dirty_new, ref_new};
            rsp_valid_in = 1'b1;
            rsp_page_in  = pg_ff;
            rsp_ref_in   = REFOUT_W'(ref_new);
            rsp_dirty_in = dirty_new;
            resp_full    = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (resp_full) begin
         rsp_phys_in = (ADDR_W'(base_ff) + ADDR_W'(rsp_page_in)) << PAGE_SHIFT;
      end else begin
         rsp_phys_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         idx_ff        <= '0;
         depth_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         base_ff       <= '0;
         page_count_ff <= PAGE_COUNT_RST;
         first_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MEM_BASE:   base_ff       <= csr_wdata[BASE_W-1:0];
               CSR_PAGE_COUNT: page_count_ff <= csr_wdata[COUNT_W-1:0];
               CSR_FIRST_FREE: first_ff      <= csr_wdata[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      pg_ff  <= pg_in;
      if (rsp_valid_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_page_ff   <= rsp_page_in;
         rsp_phys_ff   <= rsp_phys_in;
         rsp_ref_ff    <= rsp_ref_in;
         rsp_dirty_ff  <= rsp_dirty_in;
      end
   end

   assign busy           = state_ff != S_IDLE;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_page_out   = rsp_page_ff;
   assign rsp_phys_addr  = rsp_phys_ff;
   assign rsp_ref_count  = rsp_ref_ff;
   assign rsp_dirty      = rsp_dirty_ff;
   assign rsp_free_count = COUNT_W'(depth_ff);

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result shown while sequencer not idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= PAGES_DW)
      else $error("free stack depth beyond capacity");

endmodule
